// ===== src/mmm_pkg.sv =====
// Shared types and constants of the multirotor motor mixer.
package mmm_pkg;

  localparam int MOTOR_SLOTS = 16;
  localparam int FULL_SCALE = 4096;
  localparam int DIV_STEPS = 31;

  localparam logic [1:0] OP_MIX = 2'd0;
  localparam logic [1:0] OP_COEF = 2'd1;
  localparam logic [1:0] OP_OFF = 2'd2;

  localparam logic [2:0] REG_PULSE_MIN = 3'd0;
  localparam logic [2:0] REG_PULSE_MAX = 3'd1;
  localparam logic [2:0] REG_PULSE_START = 3'd2;
  localparam logic [2:0] REG_PULSE_ARM = 3'd3;
  localparam logic [2:0] REG_NOMINAL_MV = 3'd4;
  localparam logic [2:0] REG_BUS_MASK = 3'd5;
  localparam logic [2:0] REG_LIM_STEP = 3'd6;

  localparam logic [16:0] THR_MAX = 17'(FULL_SCALE * 16);
  localparam logic [15:0] LIM_MAX = 16'(FULL_SCALE * 4);
  localparam logic [12:0] LVL_MAX = 13'(FULL_SCALE);
  localparam logic [12:0] CAN_FLOOR = 13'(FULL_SCALE / 10);
  localparam longint OVER_LIM_L = longint'(FULL_SCALE) * 100 * (longint'(1) << 26);
  localparam logic signed [51:0] OVER_LIM = 52'(OVER_LIM_L);
  localparam logic signed [16:0] RECIP_100 = 17'sd41943;

  typedef struct packed {
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
    logic [15:0] pulse_start;
    logic [15:0] pulse_arm;
    logic [15:0] nominal_mv;
    logic [15:0] bus_mask;
    logic [11:0] lim_step;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [12:0]        throttle_cmd;
    logic signed [13:0] pitch_cmd;
    logic signed [13:0] roll_cmd;
    logic signed [13:0] yaw_cmd;
    logic [15:0]        battery_mv;
    logic               armed;
    logic [3:0]         coef_motor;
    logic [1:0]         coef_axis;
    logic [15:0]        coef_value;
  } in_item_t;

  typedef enum logic [2:0] {
    MUL_THR, MUL_PITCH, MUL_ROLL, MUL_YAW, MUL_SL, MUL_SH, MUL_RECIP, MUL_PWM
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_S_LOAD, ACC_S_ADD, ACC_P_LOAD, ACC_P_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    DP_NONE, DP_DIV_STEP, DP_VF, DP_LVL_PREP, DP_LVL_FIN, DP_NUM, DP_EMIT, DP_LIM
  } dp_op_e;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic [1:0] rd_axis;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    dp_op_e   dp_op;
    logic [3:0] motor;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic [MOTOR_SLOTS-1:0] active;
    logic [MOTOR_SLOTS-1:0] emit;
    logic                   out_free;
  } status_t;

endpackage

// ===== src/mmm_ctrl.sv =====
// Sequencer of the motor mixer: walks the motors and drives the datapath.
module mmm_ctrl import mmm_pkg::*; #(
  parameter int NUM_MOTORS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  output logic       in_ready_o,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_VF, ST_SCAN, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_M3, ST_A3,
    ST_P0, ST_P1, ST_P2, ST_LV0, ST_LV1, ST_LV2, ST_PW0, ST_PW1, ST_EMIT, ST_LIM
  } state_e;

  localparam logic [3:0] LAST_M = 4'(NUM_MOTORS - 1);
  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  state_e     state_q, state_d;
  logic [3:0] m_q, m_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] op_q, op_d;
  logic       accept;
  logic       advance;
  logic       is_mix;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i & in_ready_o;
  assign is_mix = (op_q == OP_MIX);

  always_comb begin
    state_d = state_q;
    m_d = m_q;
    cnt_d = cnt_q;
    op_d = op_q;
    advance = 1'b0;
    cmd_o.load = accept;
    cmd_o.rd_en = 1'b0;
    cmd_o.rd_axis = 2'd0;
    cmd_o.mul_en = 1'b0;
    cmd_o.mul_sel = MUL_THR;
    cmd_o.acc_op = ACC_NONE;
    cmd_o.dp_op = DP_NONE;
    cmd_o.motor = m_q;
    cmd_o.last = ~|((status_i.emit >> m_q) >> 1);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = in_op_i;
          m_d = 4'd0;
          cnt_d = 5'd0;
          if (in_op_i == OP_MIX) state_d = ST_DIV;
          else if (in_op_i == OP_OFF) state_d = ST_SCAN;
        end
      end
      ST_DIV: begin
        cmd_o.dp_op = DP_DIV_STEP;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) state_d = ST_VF;
      end
      ST_VF: begin
        cmd_o.dp_op = DP_VF;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (is_mix && status_i.active[m_q]) state_d = ST_RD0;
        else if (!is_mix && status_i.emit[m_q]) state_d = ST_EMIT;
        else advance = 1'b1;
      end
      ST_RD0: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_axis = 2'd0;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_axis = 2'd1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_THR;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_axis = 2'd2;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_PITCH;
        cmd_o.acc_op = ACC_S_LOAD;
        state_d = ST_RD3;
      end
      ST_RD3: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_axis = 2'd3;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_ROLL;
        cmd_o.acc_op = ACC_S_ADD;
        state_d = ST_M3;
      end
      ST_M3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_YAW;
        cmd_o.acc_op = ACC_S_ADD;
        state_d = ST_A3;
      end
      ST_A3: begin
        cmd_o.acc_op = ACC_S_ADD;
        state_d = ST_P0;
      end
      ST_P0: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_SL;
        state_d = ST_P1;
      end
      ST_P1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_SH;
        cmd_o.acc_op = ACC_P_LOAD;
        state_d = ST_P2;
      end
      ST_P2: begin
        cmd_o.acc_op = ACC_P_ADD;
        state_d = ST_LV0;
      end
      ST_LV0: begin
        cmd_o.dp_op = DP_LVL_PREP;
        state_d = ST_LV1;
      end
      ST_LV1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_RECIP;
        state_d = ST_LV2;
      end
      ST_LV2: begin
        cmd_o.dp_op = DP_LVL_FIN;
        state_d = ST_PW0;
      end
      ST_PW0: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_PWM;
        state_d = ST_PW1;
      end
      ST_PW1: begin
        cmd_o.dp_op = DP_NUM;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.emit[m_q]) begin
          advance = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.dp_op = DP_EMIT;
          advance = 1'b1;
        end
      end
      ST_LIM: begin
        cmd_o.dp_op = DP_LIM;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (advance) begin
      if (m_q == LAST_M) begin
        state_d = ST_LIM;
      end else begin
        m_d = m_q + 4'd1;
        state_d = ST_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_q <= 4'd0;
      cnt_q <= 5'd0;
      op_q <= OP_MIX;
    end else begin
      state_q <= state_d;
      m_q <= m_d;
      cnt_q <= cnt_d;
      op_q <= op_d;
    end
  end

endmodule

// ===== src/mmm_dp.sv =====
// Datapath of the motor mixer: coefficient memory, divider, shared multiplier, output register.
module mmm_dp import mmm_pkg::*; #(
  parameter int NUM_MOTORS = 16,
  parameter int PWM_PORTS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  in_item_t    item_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  out_motor_o,
  output logic        out_kind_o,
  output logic [15:0] out_drive_o,
  output logic [12:0] out_level_o,
  output logic        out_last_o
);

  localparam int DEPTH = NUM_MOTORS * 4;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] nz_q;
  logic [15:0]      rdata_q;
  logic             rnz_q;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             wr_en;

  logic [16:0]        thr16_q;
  logic signed [13:0] pc_q, rc_q, yc_q;
  logic               armed_q, mix_q;
  logic [30:0]        quo_q;
  logic [15:0]        rem_q;
  logic               neg_q;
  logic signed [15:0] vf_q;
  logic signed [36:0] prod_q;
  logic signed [35:0] s_q;
  logic signed [51:0] p_q;
  logic               over_q;
  logic [18:0]        x_q;
  logic [12:0]        lvl_q;
  logic signed [31:0] num_q;
  logic [17:0]        lim_acc_q;
  logic [15:0]        limiter_q;

  logic               out_valid_q, out_kind_q, out_last_q;
  logic [3:0]         out_motor_q;
  logic [15:0]        out_drive_q;
  logic [12:0]        out_level_q;

  logic [15:0]        nom;
  logic signed [17:0] thr_raw, vnum;
  logic [16:0]        vmag;
  logic [16:0]        div_t;
  logic               div_ge;
  logic signed [15:0] coef;
  logic signed [19:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [16:0] pw_span;
  logic [12:0]        q0;
  logic [19:0]        rem100;
  logic signed [19:0] pw_x;
  logic [15:0]        pwm_drive, can_drive, emit_drive;
  logic [12:0]        can_c;
  logic [16:0]        can_s;
  logic [17:0]        lim_sub;
  logic               kind;

  for (genvar i = 0; i < MOTOR_SLOTS; i++) begin : g_slot
    if (i < NUM_MOTORS) begin : g_on
      assign status_o.active[i] = |nz_q[4*i +: 4];
      assign status_o.emit[i] = status_o.active[i] & (cfg_i.bus_mask[i] | (i < PWM_PORTS));
    end else begin : g_off
      assign status_o.active[i] = 1'b0;
      assign status_o.emit[i] = 1'b0;
    end
  end
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  assign wr_en = cmd_i.load & (item_i.op == OP_COEF) & (int'(item_i.coef_motor) < NUM_MOTORS);
  assign wr_addr = AW'({item_i.coef_motor, item_i.coef_axis});
  assign rd_addr = AW'({cmd_i.motor, cmd_i.rd_axis});

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= item_i.coef_value;
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
      rnz_q <= nz_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= '0;
    end else if (wr_en) begin
      nz_q[wr_addr] <= |item_i.coef_value;
    end
  end

  assign nom = (cfg_i.nominal_mv == 16'd0) ? 16'd1 : cfg_i.nominal_mv;
  assign thr_raw = $signed({1'b0, item_i.throttle_cmd, 4'b0}) - $signed({2'b0, limiter_q});
  assign vnum = $signed({1'b0, nom, 1'b0}) - $signed({2'b0, item_i.battery_mv});
  assign vmag = vnum[17] ? 17'(-vnum) : vnum[16:0];
  assign div_t = {rem_q, quo_q[30]};
  assign div_ge = div_t >= {1'b0, nom};
  assign coef = rnz_q ? $signed(rdata_q) : 16'sd0;
  assign pw_span = $signed({1'b0, cfg_i.pulse_max}) - $signed({1'b0, cfg_i.pulse_min});

  always_comb begin
    mul_a = {3'b0, thr16_q};
    mul_b = {coef[15], coef};
    case (cmd_i.mul_sel)
      MUL_THR:   mul_a = {3'b0, thr16_q};
      MUL_PITCH: mul_a = {{6{pc_q[13]}}, pc_q};
      MUL_ROLL:  mul_a = {{6{rc_q[13]}}, rc_q};
      MUL_YAW:   mul_a = {{6{yc_q[13]}}, yc_q};
      MUL_SL: begin
        mul_a = {1'b0, s_q[18:0]};
        mul_b = {vf_q[15], vf_q};
      end
      MUL_SH: begin
        mul_a = {{3{s_q[35]}}, s_q[35:19]};
        mul_b = {vf_q[15], vf_q};
      end
      MUL_RECIP: begin
        mul_a = {1'b0, x_q};
        mul_b = RECIP_100;
      end
      MUL_PWM: begin
        mul_a = {7'b0, lvl_q};
        mul_b = pw_span;
      end
      default: mul_a = {3'b0, thr16_q};
    endcase
  end

  assign q0 = prod_q[34:22];
  assign rem100 = {1'b0, x_q} - 20'(q0 * 7'd100);

  assign pw_x = num_q[31] ? 20'((num_q + 32'sd4095) >>> 12) : 20'(num_q >>> 12);
  always_comb begin
    if (pw_x < $signed({4'b0, cfg_i.pulse_start})) pwm_drive = cfg_i.pulse_start;
    else if (pw_x > $signed({4'b0, cfg_i.pulse_max})) pwm_drive = cfg_i.pulse_max;
    else pwm_drive = pw_x[15:0];
  end
  assign can_c = (lvl_q < CAN_FLOOR) ? CAN_FLOOR : lvl_q;
  assign can_s = {can_c, 4'b0};
  assign can_drive = can_s[16] ? 16'hFFFF : can_s[15:0];
  assign kind = cfg_i.bus_mask[cmd_i.motor];

  always_comb begin
    emit_drive = 16'd0;
    if (armed_q) begin
      if (mix_q) emit_drive = kind ? can_drive : pwm_drive;
      else if (!kind) emit_drive = cfg_i.pulse_arm;
    end
  end

  assign lim_sub = (lim_acc_q > {6'b0, cfg_i.lim_step}) ? lim_acc_q - {6'b0, cfg_i.lim_step}
                                                          : 18'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (thr_raw < 0) thr16_q <= 17'd0;
      else if (thr_raw > $signed({1'b0, THR_MAX})) thr16_q <= THR_MAX;
      else thr16_q <= thr_raw[16:0];
      pc_q <= item_i.pitch_cmd;
      rc_q <= item_i.roll_cmd;
      yc_q <= item_i.yaw_cmd;
      armed_q <= item_i.armed;
      mix_q <= (item_i.op == OP_MIX);
      neg_q <= vnum[17];
      quo_q <= {vmag, 14'b0};
      rem_q <= 16'd0;
      lim_acc_q <= {2'b0, limiter_q};
    end
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    case (cmd_i.acc_op)
      ACC_S_LOAD: s_q <= prod_q[35:0];
      ACC_S_ADD:  s_q <= s_q + $signed({prod_q[31:0], 4'b0});
      ACC_P_LOAD: p_q <= {{15{prod_q[36]}}, prod_q};
      ACC_P_ADD:  p_q <= p_q + $signed({prod_q[32:0], 19'b0});
      default: ;
    endcase
    case (cmd_i.dp_op)
      DP_DIV_STEP: begin
        rem_q <= div_ge ? 16'(div_t - {1'b0, nom}) : div_t[15:0];
        quo_q <= {quo_q[29:0], div_ge};
      end
      DP_VF: begin
        if (neg_q) vf_q <= (quo_q > 31'd32768) ? -16'sd32768 : 16'(-quo_q);
        else vf_q <= (quo_q > 31'd32767) ? 16'sd32767 : quo_q[15:0];
      end
      DP_LVL_PREP: begin
        over_q <= p_q >= OVER_LIM;
        x_q <= (p_q > 0 && p_q < OVER_LIM) ? p_q[44:26] : 19'd0;
      end
      DP_LVL_FIN: begin
        if (over_q) lvl_q <= LVL_MAX;
        else lvl_q <= (rem100 >= 20'd100) ? q0 + 13'd1 : q0;
        if (over_q) lim_acc_q <= lim_acc_q + {6'b0, cfg_i.lim_step};
      end
      DP_NUM: num_q <= prod_q[31:0] + $signed({4'b0, cfg_i.pulse_min, 12'b0});
      default: ;
    endcase
    if (cmd_i.dp_op == DP_EMIT) begin
      out_motor_q <= cmd_i.motor;
      out_kind_q <= kind;
      out_drive_q <= emit_drive;
      out_level_q <= mix_q ? lvl_q : 13'd0;
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limiter_q <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.dp_op == DP_LIM) begin
        if (!mix_q) limiter_q <= 16'd0;
        else if (lim_sub > {2'b0, LIM_MAX}) limiter_q <= LIM_MAX;
        else limiter_q <= lim_sub[15:0];
      end
      if (cmd_i.dp_op == DP_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_motor_o = out_motor_q;
  assign out_kind_o = out_kind_q;
  assign out_drive_o = out_drive_q;
  assign out_level_o = out_level_q;
  assign out_last_o = out_last_q;

endmodule

// ===== src/multirotor_motor_mixer_top.sv =====
// Top level of the multirotor motor mixer: stream ports, register file, sequencer and datapath.
//
// Requests arrive on the s_axis channel; tuser carries the op (mix, coefficient write,
// motors off). A coefficient write gives no result. A mix request runs a voltage-factor
// division, then walks the motors in index order; each active motor uses the single
// shared 20x17 multiplier. A motors-off request also walks the motors in index order.
// Each active motor with a port gives one result on m_axis: tuser is the bus kind, tlast
// marks the final result of the request. Results leave through an output register; while
// the receiver stalls, the walk holds at the next result. s_axis_tready is high only
// between requests. Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write them only while idle, which the block itself does not enforce.
// Reset clears the coefficient table (per-entry nonzero flags), the limiter and restores
// the register defaults; the block is ready as soon as reset is released.
module multirotor_motor_mixer_top import mmm_pkg::*; #(
  parameter int NUM_MOTORS = 16,
  parameter int PWM_PORTS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // throttle_cmd, pitch_cmd, roll_cmd, yaw_cmd, battery_mv, armed, coef_motor,
  // coef_axis, coef_value, zero fill
  input  logic [95:0] s_axis_tdata,
  // op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motor_index, drive, level, zero fill
  output logic [39:0] m_axis_tdata,
  // bus_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t     cfg_q;
  in_item_t item;
  cmd_t     cmd;
  status_t  status;
  logic [3:0]  out_motor;
  logic [15:0] out_drive;
  logic [12:0] out_level;

  assign item.op = s_axis_tuser;
  assign item.throttle_cmd = s_axis_tdata[12:0];
  assign item.pitch_cmd = s_axis_tdata[26:13];
  assign item.roll_cmd = s_axis_tdata[40:27];
  assign item.yaw_cmd = s_axis_tdata[54:41];
  assign item.battery_mv = s_axis_tdata[70:55];
  assign item.armed = s_axis_tdata[71];
  assign item.coef_motor = s_axis_tdata[75:72];
  assign item.coef_axis = s_axis_tdata[77:76];
  assign item.coef_value = s_axis_tdata[93:78];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min <= 16'd1000;
      cfg_q.pulse_max <= 16'd2000;
      cfg_q.pulse_start <= 16'd1100;
      cfg_q.pulse_arm <= 16'd975;
      cfg_q.nominal_mv <= 16'd11100;
      cfg_q.bus_mask <= 16'd0;
      cfg_q.lim_step <= 12'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PULSE_MIN:   cfg_q.pulse_min <= cfg_data_i;
        REG_PULSE_MAX:   cfg_q.pulse_max <= cfg_data_i;
        REG_PULSE_START: cfg_q.pulse_start <= cfg_data_i;
        REG_PULSE_ARM:   cfg_q.pulse_arm <= cfg_data_i;
        REG_NOMINAL_MV:  cfg_q.nominal_mv <= cfg_data_i;
        REG_BUS_MASK:    cfg_q.bus_mask <= cfg_data_i;
        REG_LIM_STEP:    cfg_q.lim_step <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  mmm_ctrl #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_op_i(s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .status_i(status),
    .cmd_o(cmd)
  );

  mmm_dp #(
    .NUM_MOTORS(NUM_MOTORS),
    .PWM_PORTS(PWM_PORTS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i(cfg_q),
    .item_i(item),
    .cmd_i(cmd),
    .status_o(status),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_motor_o(out_motor),
    .out_kind_o(m_axis_tuser),
    .out_drive_o(out_drive),
    .out_level_o(out_level),
    .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, out_level, out_drive, out_motor};

endmodule
